### sv/lefgfs_pkg.sv
// Package for the light effect engine: payload and configuration types,
// effect mode and register index codes, and level format constants.
// No dependencies; every other file in the project uses this package.
package lefgfs_pkg;

   localparam int LEVEL_FRAC_BITS = 16;
   localparam int LEVEL_INT_BITS  = 8;
   localparam int LEVEL_W         = LEVEL_INT_BITS + LEVEL_FRAC_BITS;
   localparam int STEP_W          = LEVEL_W + 1;
   localparam int TICKS_W         = 8;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {{LEVEL_INT_BITS{1'b1}}, {LEVEL_FRAC_BITS{1'b0}}};

   typedef enum logic [1:0] {
      MODE_FADE    = 2'd0,
      MODE_GLOW    = 2'd1,
      MODE_FLICKER = 2'd2,
      MODE_STROBE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_EFFECT_MODE = 3'd0,
      REG_UPPER_LEVEL = 3'd1,
      REG_LOWER_LEVEL = 3'd2,
      REG_STEP_DELTA  = 3'd3,
      REG_UPPER_TICKS = 3'd4,
      REG_LOWER_TICKS = 3'd5,
      REG_START_LEVEL = 3'd6
   } reg_index_type;

   typedef struct packed {
      mode_type                    effect_mode;
      logic [LEVEL_INT_BITS-1:0]   upper_level;
      logic [LEVEL_INT_BITS-1:0]   lower_level;
      logic signed [STEP_W-1:0]    step_delta;
      logic [TICKS_W-1:0]          upper_ticks;
      logic [TICKS_W-1:0]          lower_ticks;
      logic [LEVEL_INT_BITS-1:0]   start_level;
   } cfg_type;

   typedef struct packed {
      logic       func;
      logic [7:0] random_byte;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_out;
      logic               finished;
   } rsp_payload_type;

endpackage

### sv/light_effect_fade_glow_flicker_strobe.sv
// Top level of the light effect engine: input register, effect core,
// result register and configuration registers.
// Depends on lefgfs_pkg, lefgfs_csr and lefgfs_core.
//
// Usage: each transaction on the req_ channel is a tick (func 0) or a
// restart (func 1) and carries a random byte for flicker hold counts.
// Every transaction yields exactly one rsp_ transaction carrying the
// brightness in unsigned 8.16 fixed point and the fade finished flag.
// The transaction is captured in an input register, where the effect logic
// (a saturating add, a compare and a select) works on it; when the result
// register is free or draining, the state and the result register are
// loaded with the outcome and rsp_valid rises. Throughput is one
// transaction per cycle while the receiver holds rsp_ready high.
// While the receiver holds rsp_ready low, the result stays in its register
// and one further transaction may be captured in the input register before
// req_ready falls. Configuration is written through the csr_ port; the user
// must write it only while the block is idle, which the block itself does not
// enforce. Synchronous reset empties both registers, restores the effect state
// (level 0, rising) and the configuration defaults (upper level 255, all else 0).
module light_effect_fade_glow_flicker_strobe (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lefgfs_pkg::req_payload_type       req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lefgfs_pkg::rsp_payload_type       rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lefgfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lefgfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lefgfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);

   lefgfs_pkg::cfg_type         cfg;
   lefgfs_pkg::req_payload_type in_item_ff;
   logic                        in_valid_ff;
   lefgfs_pkg::rsp_payload_type result;
   lefgfs_pkg::rsp_payload_type rsp_data_ff;
   logic                        rsp_valid_ff;
   logic                        advance;
   logic                        req_fire;

   // The held item moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_fire  = req_valid & req_ready;

   lefgfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lefgfs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### sv/lefgfs_csr.sv
// Configuration register file behind the APB-style port.
// Depends on lefgfs_pkg for the register index codes and cfg_type.
module lefgfs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lefgfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lefgfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lefgfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready,
   output lefgfs_pkg::cfg_type               cfg
);

   lefgfs_pkg::cfg_type       cfg_ff;
   lefgfs_pkg::cfg_type       cfg_in;
   lefgfs_pkg::reg_index_type index;
   logic                      write_en;

   assign index      = lefgfs_pkg::reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            lefgfs_pkg::REG_EFFECT_MODE:
               cfg_in.effect_mode = lefgfs_pkg::mode_type'(csr_pwdata[1:0]);
            lefgfs_pkg::REG_UPPER_LEVEL: cfg_in.upper_level = csr_pwdata[7:0];
            lefgfs_pkg::REG_LOWER_LEVEL: cfg_in.lower_level = csr_pwdata[7:0];
            lefgfs_pkg::REG_STEP_DELTA:
               cfg_in.step_delta = csr_pwdata[lefgfs_pkg::STEP_W-1:0];
            lefgfs_pkg::REG_UPPER_TICKS: cfg_in.upper_ticks = csr_pwdata[7:0];
            lefgfs_pkg::REG_LOWER_TICKS: cfg_in.lower_ticks = csr_pwdata[7:0];
            lefgfs_pkg::REG_START_LEVEL: cfg_in.start_level = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         lefgfs_pkg::REG_EFFECT_MODE: csr_prdata = 32'(cfg_ff.effect_mode);
         lefgfs_pkg::REG_UPPER_LEVEL: csr_prdata = 32'(cfg_ff.upper_level);
         lefgfs_pkg::REG_LOWER_LEVEL: csr_prdata = 32'(cfg_ff.lower_level);
         lefgfs_pkg::REG_STEP_DELTA:  csr_prdata = 32'(unsigned'(cfg_ff.step_delta));
         lefgfs_pkg::REG_UPPER_TICKS: csr_prdata = 32'(cfg_ff.upper_ticks);
         lefgfs_pkg::REG_LOWER_TICKS: csr_prdata = 32'(cfg_ff.lower_ticks);
         lefgfs_pkg::REG_START_LEVEL: csr_prdata = 32'(cfg_ff.start_level);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{effect_mode: lefgfs_pkg::MODE_FADE,
                     upper_level: 8'hFF,
                     lower_level: '0,
                     step_delta:  '0,
                     upper_ticks: '0,
                     lower_ticks: '0,
                     start_level: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/lefgfs_core.sv
// Effect state registers and the single-pass next-state logic for one item.
// Depends on lefgfs_pkg for the configuration, payload and mode types.
module lefgfs_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  lefgfs_pkg::req_payload_type item,
   input  lefgfs_pkg::cfg_type         cfg,
   output lefgfs_pkg::rsp_payload_type result
);

   localparam int LW = lefgfs_pkg::LEVEL_W;
   localparam int SW = lefgfs_pkg::STEP_W;
   localparam int TW = lefgfs_pkg::TICKS_W;

   logic [LW-1:0]        bright_level_ff, bright_level_in;
   logic [TW-1:0]        hold_counter_ff, hold_counter_in;
   logic signed [SW-1:0] glow_step_ff,    glow_step_in;
   logic                 rising_ff,       rising_in;
   logic                 fade_done_ff,    fade_done_in;

   logic [LW-1:0] up_level;
   logic [LW-1:0] lo_level;
   logic [LW-1:0] start_lvl;
   logic [LW-1:0] fade_sum;
   logic [LW-1:0] glow_sum;

   // Level plus signed step, clamped to the range 0 .. 255.0.
   function automatic logic [LW-1:0] add_sat(input logic [LW-1:0] lvl,
                                             input logic [SW-1:0] step);
      logic [SW:0] sum;
      logic [LW-1:0] res;
      sum = {2'b00, lvl} + {step[SW-1], step};
      if (sum[SW])
         res = '0;
      else if (sum[SW-1:0] > {1'b0, lefgfs_pkg::LEVEL_MAX})
         res = lefgfs_pkg::LEVEL_MAX;
      else
         res = sum[LW-1:0];
      return res;
   endfunction

   assign up_level  = {cfg.upper_level, {lefgfs_pkg::LEVEL_FRAC_BITS{1'b0}}};
   assign lo_level  = {cfg.lower_level, {lefgfs_pkg::LEVEL_FRAC_BITS{1'b0}}};
   assign start_lvl = {cfg.start_level, {lefgfs_pkg::LEVEL_FRAC_BITS{1'b0}}};
   assign fade_sum  = add_sat(bright_level_ff, cfg.step_delta);
   assign glow_sum  = add_sat(bright_level_ff, glow_step_ff);

   always_comb begin
      bright_level_in = bright_level_ff;
      hold_counter_in = hold_counter_ff;
      glow_step_in    = glow_step_ff;
      rising_in       = rising_ff;
      fade_done_in    = fade_done_ff;
      if (item.func) begin
         fade_done_in = 1'b0;
         glow_step_in = cfg.step_delta;
         rising_in    = (cfg.start_level <= cfg.upper_level);
         unique case (cfg.effect_mode)
            lefgfs_pkg::MODE_FADE, lefgfs_pkg::MODE_GLOW: begin
               bright_level_in = start_lvl;
               hold_counter_in = '0;
            end
            lefgfs_pkg::MODE_FLICKER: begin
               bright_level_in = up_level;
               hold_counter_in = {1'b0, item.random_byte[6], 6'b000000} + 8'd1;
            end
            default: begin
               bright_level_in = up_level;
               hold_counter_in = cfg.upper_ticks;
            end
         endcase
      end else if (!fade_done_ff) begin
         if (hold_counter_ff != '0) begin
            hold_counter_in = hold_counter_ff - 8'd1;
         end else begin
            unique case (cfg.effect_mode)
               lefgfs_pkg::MODE_FADE: begin
                  if (rising_ff ? (fade_sum >= up_level) : (fade_sum <= up_level)) begin
                     bright_level_in = up_level;
                     fade_done_in    = 1'b1;
                  end else begin
                     bright_level_in = fade_sum;
                  end
               end
               lefgfs_pkg::MODE_GLOW: begin
                  bright_level_in = glow_sum;
                  if (rising_ff) begin
                     if (glow_sum >= up_level) begin
                        bright_level_in = up_level;
                        glow_step_in    = -glow_step_ff;
                        rising_in       = 1'b0;
                     end
                  end else if (glow_sum <= lo_level) begin
                     bright_level_in = lo_level;
                     glow_step_in    = -glow_step_ff;
                     rising_in       = 1'b1;
                  end
               end
               lefgfs_pkg::MODE_FLICKER: begin
                  if (bright_level_ff == up_level) begin
                     bright_level_in = lo_level;
                     hold_counter_in = {5'b00000, item.random_byte[2:0]} + 8'd1;
                  end else begin
                     bright_level_in = up_level;
                     hold_counter_in = {3'b000, item.random_byte[4:0]} + 8'd1;
                  end
               end
               default: begin
                  if (bright_level_ff == up_level) begin
                     bright_level_in = lo_level;
                     hold_counter_in = cfg.lower_ticks;
                  end else begin
                     bright_level_in = up_level;
                     hold_counter_in = cfg.upper_ticks;
                  end
               end
            endcase
         end
      end
   end

   assign result.level_out = bright_level_in;
   assign result.finished  = fade_done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_level_ff <= '0;
         hold_counter_ff <= '0;
         glow_step_ff    <= '0;
         rising_ff       <= 1'b1;
         fade_done_ff    <= 1'b0;
      end else if (advance) begin
         bright_level_ff <= bright_level_in;
         hold_counter_ff <= hold_counter_in;
         glow_step_ff    <= glow_step_in;
         rising_ff       <= rising_in;
         fade_done_ff    <= fade_done_in;
      end
   end

endmodule
